FILE: hdl/pc2d_pkg.sv
package pc2d_pkg;

  // Widths that cover the whole supported parameter range.
  localparam int SLOT_W  = 4;   // line slot, kernel side up to 15
  localparam int COL_W   = 14;  // column address into one line, up to 16383
  localparam int CH_W    = 4;   // channel count up to 7
  localparam int HALF_W  = 3;
  localparam int SHIFT_W = 5;
  localparam int ACC_W   = 48;

  // Configuration register indexes.
  localparam logic [2:0] REG_HALF_SIZE    = 3'd0;
  localparam logic [2:0] REG_ROW_SIZE     = 3'd1;
  localparam logic [2:0] REG_CHANNELS     = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT    = 3'd3;
  localparam logic [2:0] REG_RESULT_SHIFT = 3'd4;

  // Input item kinds.
  localparam logic FUNC_COEF  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic               func;
    logic [6:0]         coef_index;
    logic [15:0]        value;
    logic               produce;
    logic               last;
    logic [SLOT_W-1:0]  wr_slot;
    logic [COL_W-1:0]   wr_col;
    logic [SLOT_W-1:0]  rd_slot;
    logic [COL_W-1:0]   rd_col;
    logic [SLOT_W-1:0]  side;
    logic [CH_W-1:0]    ch;
    logic [SHIFT_W-1:0] shift;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

FILE: hdl/padded_2d_convolution.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  func, coef_index, coef_value, pixel_value
// out_     output     out_valid/out_stall result_value, saturated, last_of_image
// cfg_     input      cfg_valid/cfg_ready index, data
//
// A coefficient or a pixel with no result is written to its store as the back end takes it.
// A pixel that yields a result is handled by the tap sequencer, which reads one
// line store entry and one coefficient per cycle.
// Reset is synchronous; it clears counters, queue and handshakes and loads the
// register defaults, while the line and coefficient stores keep their contents.
// The two-entry queue lets the input run ahead while the output is stalled.
module padded_2d_convolution #(
  parameter int MAX_HALF_SIZE  = 4,
  parameter int MAX_PADDED_ROW = 2048,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [6:0]  in_coef_index,
  input  logic [15:0] in_coef_value,
  input  logic [15:0] in_pixel_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic        out_saturated,
  output logic        out_last_of_image
);
  import pc2d_pkg::*;

  job_t fj, qj;
  logic full, avail, pop, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign take      = in_valid && !full;

  pc2d_front #(
    .MAX_HALF_SIZE(MAX_HALF_SIZE),
    .MAX_PADDED_ROW(MAX_PADDED_ROW),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_take(take), .in_func(in_func), .in_coef_index(in_coef_index),
    .in_coef_value(in_coef_value), .in_pixel_value(in_pixel_value),
    .job(fj)
  );

  pc2d_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(take), .push_data(fj), .full(full),
    .pop(pop), .avail(avail), .pop_data(qj)
  );

  pc2d_back #(
    .MAX_HALF_SIZE(MAX_HALF_SIZE),
    .MAX_PADDED_ROW(MAX_PADDED_ROW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_avail(avail), .q_data(qj), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_saturated(out_saturated),
    .out_last_of_image(out_last_of_image)
  );

endmodule

FILE: hdl/pc2d_front.sv
module pc2d_front #(
  parameter int MAX_HALF_SIZE  = 4,
  parameter int MAX_PADDED_ROW = 2048,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_take,
  input  logic              in_func,
  input  logic [6:0]        in_coef_index,
  input  logic [15:0]       in_coef_value,
  input  logic [15:0]       in_pixel_value,
  output pc2d_pkg::job_t    job
);
  import pc2d_pkg::*;

  logic [2:0]  half_r;
  logic [11:0] row_size_r;
  logic [2:0]  ch_r;
  logic [15:0] row_count_r;
  logic [4:0]  shift_r;

  logic [12:0]       pc_r, pc_nxt;
  logic [16:0]       pr_r, pr_nxt;
  logic [COL_W-1:0]  pcm_r, pcm_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [2:0]        h_e;
  logic [CH_W-1:0]   ch_e;
  logic [SLOT_W-1:0] side;
  logic [6:0]        span;
  logic [12:0]       prow;
  logic [16:0]       rows;
  logic [SLOT_W-1:0] slot_inc;
  logic              geo_wr;

  // Geometry with out-of-range values clamped.
  always_comb begin
    h_e  = (int'(half_r) > MAX_HALF_SIZE) ? 3'(MAX_HALF_SIZE) : half_r;
    if (ch_r == 3'd0) begin
      ch_e = CH_W'(1);
    end else if (int'(ch_r) > MAX_CHANNELS) begin
      ch_e = CH_W'(MAX_CHANNELS);
    end else begin
      ch_e = CH_W'(ch_r);
    end
    side = SLOT_W'({h_e, 1'b1});
    span = 7'(h_e) * 7'(ch_e) * 7'd2;
    prow = ((row_size_r == 12'd0) ? 13'd1 : 13'(row_size_r)) + 13'(span);
    rows = ((row_count_r == 16'd0) ? 17'd1 : 17'(row_count_r)) + 17'({h_e, 1'b0});
    slot_inc = (slot_r + SLOT_W'(1) == side) ? '0 : slot_r + SLOT_W'(1);
  end

  // Classification of the item at the current position.
  always_comb begin
    job.func       = in_func;
    job.coef_index = in_coef_index;
    job.value      = (in_func == FUNC_COEF) ? in_coef_value : in_pixel_value;
    job.produce    = (pr_r >= 17'({h_e, 1'b0})) && (pc_r >= 13'(span));
    job.last       = (pc_r + 13'd1 >= prow) && (pr_r + 17'd1 >= rows);
    job.wr_slot    = slot_r;
    job.wr_col     = pcm_r;
    job.rd_slot    = slot_inc;
    if (pcm_r >= COL_W'(span)) begin
      job.rd_col = pcm_r - COL_W'(span);
    end else begin
      job.rd_col = COL_W'(int'(pcm_r) + MAX_PADDED_ROW - int'(span));
    end
    job.side  = side;
    job.ch    = ch_e;
    job.shift = shift_r;
  end

  assign geo_wr = cfg_valid &&
                  (cfg_index inside {REG_HALF_SIZE, REG_ROW_SIZE, REG_CHANNELS, REG_ROW_COUNT});

  // Position counters advance on each pixel transaction and restart on a geometry register write.
  always_comb begin
    pc_nxt   = pc_r;
    pr_nxt   = pr_r;
    pcm_nxt  = pcm_r;
    slot_nxt = slot_r;
    if (geo_wr) begin
      pc_nxt   = '0;
      pr_nxt   = '0;
      pcm_nxt  = '0;
      slot_nxt = '0;
    end else if (in_take && in_func == FUNC_PIXEL) begin
      if (pc_r + 13'd1 >= prow) begin
        pc_nxt  = '0;
        pcm_nxt = '0;
        if (pr_r + 17'd1 >= rows) begin
          pr_nxt   = '0;
          slot_nxt = '0;
        end else begin
          pr_nxt   = pr_r + 17'd1;
          slot_nxt = slot_inc;
        end
      end else begin
        pc_nxt  = pc_r + 13'd1;
        pcm_nxt = (int'(pcm_r) + 1 == MAX_PADDED_ROW) ? '0 : pcm_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= 3'd1;
      row_size_r  <= 12'd64;
      ch_r        <= 3'd1;
      row_count_r <= 16'd64;
      shift_r     <= 5'd14;
      pc_r        <= '0;
      pr_r        <= '0;
      pcm_r       <= '0;
      slot_r      <= '0;
    end else begin
      pc_r   <= pc_nxt;
      pr_r   <= pr_nxt;
      pcm_r  <= pcm_nxt;
      slot_r <= slot_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_HALF_SIZE:    half_r      <= cfg_data[2:0];
          REG_ROW_SIZE:     row_size_r  <= cfg_data[11:0];
          REG_CHANNELS:     ch_r        <= cfg_data[2:0];
          REG_ROW_COUNT:    row_count_r <= cfg_data;
          REG_RESULT_SHIFT: shift_r     <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/pc2d_queue.sv
module pc2d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pc2d_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output pc2d_pkg::job_t pop_data
);
  import pc2d_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  // Two-entry circular queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: hdl/pc2d_back.sv
module pc2d_back #(
  parameter int MAX_HALF_SIZE  = 4,
  parameter int MAX_PADDED_ROW = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_avail,
  input  pc2d_pkg::job_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_result_value,
  output logic           out_saturated,
  output logic           out_last_of_image
);
  import pc2d_pkg::*;

  localparam int SIDE_MAX   = 2 * MAX_HALF_SIZE + 1;
  localparam int TAPS_MAX   = SIDE_MAX * SIDE_MAX;
  localparam int LINE_DEPTH = SIDE_MAX * MAX_PADDED_ROW;
  localparam int LA_W       = $clog2(LINE_DEPTH);
  localparam int CA_W       = $clog2(TAPS_MAX);

  logic signed [15:0] line_mem [LINE_DEPTH];
  logic signed [15:0] coef_mem [TAPS_MAX];

  state_t state_r, state_nxt;
  job_t   e_r, e_nxt;

  logic [SLOT_W-1:0] rs_r, rs_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [COL_W-1:0]  rc_r, rc_nxt;
  logic [CA_W-1:0]   k_r, k_nxt;
  logic              issue;
  logic              v1_r, v2_r;
  logic signed [15:0] ld_r, cd_r;
  logic signed [31:0] p_r;
  logic signed [ACC_W-1:0] acc_r;
  logic              acc_clr;
  logic              line_we, coef_we;
  logic [LA_W-1:0]   line_wa, line_ra;
  logic [COL_W:0]    rc_sum;
  logic signed [ACC_W-1:0] shd;
  logic [31:0]       res;
  logic              sat;
  logic              out_load;
  logic              ovalid_r;

  assign line_wa = LA_W'(q_data.wr_slot) * LA_W'(MAX_PADDED_ROW) + LA_W'(q_data.wr_col);
  assign line_ra = LA_W'(rs_r) * LA_W'(MAX_PADDED_ROW) + LA_W'(rc_r);
  assign rc_sum  = {1'b0, rc_r} + (COL_W + 1)'(e_r.ch);

  // Final shift and saturation of the sum.
  always_comb begin
    shd = acc_r >>> e_r.shift;
    if (shd > ACC_W'(signed'(33'sh0_7FFF_FFFF))) begin
      res = 32'h7FFF_FFFF;
      sat = 1'b1;
    end else if (shd < ACC_W'(signed'(-33'sh0_8000_0000))) begin
      res = 32'h8000_0000;
      sat = 1'b1;
    end else begin
      res = shd[31:0];
      sat = 1'b0;
    end
  end

  // Tap sequencer.
  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    rs_nxt    = rs_r;
    rc_nxt    = rc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    line_we   = 1'b0;
    coef_we   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          e_nxt = q_data;
          if (q_data.func == FUNC_COEF) begin
            coef_we = (int'(q_data.coef_index) < TAPS_MAX);
          end else begin
            line_we = 1'b1;
            if (q_data.produce) begin
              state_nxt = S_TAP;
              rs_nxt    = q_data.rd_slot;
              rc_nxt    = q_data.rd_col;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              acc_clr   = 1'b1;
            end
          end
        end
      end
      S_TAP: begin
        issue = 1'b1;
        k_nxt = k_r + CA_W'(1);
        if (j_r == e_r.side - SLOT_W'(1)) begin
          j_nxt  = '0;
          i_nxt  = i_r + SLOT_W'(1);
          rs_nxt = (rs_r + SLOT_W'(1) == e_r.side) ? '0 : rs_r + SLOT_W'(1);
          rc_nxt = e_r.rd_col;
          if (i_r == e_r.side - SLOT_W'(1)) state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + SLOT_W'(1);
          if (int'(rc_sum) >= MAX_PADDED_ROW) begin
            rc_nxt = COL_W'(int'(rc_sum) - MAX_PADDED_ROW);
          end else begin
            rc_nxt = rc_sum[COL_W-1:0];
          end
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Datapath: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    e_r  <= e_nxt;
    rs_r <= rs_nxt;
    rc_r <= rc_nxt;
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    if (v1_r) p_r <= ld_r * cd_r;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(p_r);
    end
    if (out_load) begin
      out_result_value  <= res;
      out_saturated     <= sat;
      out_last_of_image <= e_r.last;
    end
  end

  // Line and coefficient memories with registered reads.
  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_wa] <= q_data.value;
    if (coef_we) coef_mem[CA_W'(q_data.coef_index)] <= q_data.value;
    ld_r <= line_mem[line_ra];
    cd_r <= coef_mem[k_r];
  end

  assign out_valid = ovalid_r;

endmodule

FILE: hdl/pc2d_checker.sv
module pc2d_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_value,
  input logic        out_saturated,
  input logic        cfg_ready
);

  // A stalled result transaction stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Nothing is offered right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("busy after reset");

  // A clipped result is one of the two limits.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_result_value == 32'h7FFF_FFFF || out_result_value == 32'h8000_0000))
    else $error("saturation flag without limit value");

  // Configuration is always taken.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind padded_2d_convolution pc2d_props u_pc2d_props (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_result_value(out_result_value),
  .out_saturated(out_saturated), .cfg_ready(cfg_ready)
);

FILE: test/pc2d_checker.sv
`timescale 1ns / 1ps

module pc2d_checker #(
  parameter int MAX_HALF_SIZE  = 4,
  parameter int MAX_PADDED_ROW = 2048,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [6:0]  in_coef_index,
  input  logic [15:0] in_coef_value,
  input  logic [15:0] in_pixel_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result_value,
  input  logic        out_saturated,
  input  logic        out_last_of_image,
  output int          errors,
  output int          outstanding
);
  import pc2d_pkg::*;

  localparam int SIDE_MAX = 2 * MAX_HALF_SIZE + 1;
  localparam int TAPS_MAX = SIDE_MAX * SIDE_MAX;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
    logic        last;
  } conv_result_t;

  conv_result_t       conv_results_q[$];
  logic [2:0]         half_q;
  logic [11:0]        rowsz_q;
  logic [2:0]         chan_q;
  logic [15:0]        rowcnt_q;
  logic [4:0]         shift_q;
  logic signed [15:0] kernel_taps[TAPS_MAX];
  logic signed [15:0] line_rows[SIDE_MAX][MAX_PADDED_ROW];
  int unsigned        col_pos;
  int unsigned        row_pos;
  int                 mismatch_cnt;

  assign errors = mismatch_cnt;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // Register write; geometry registers restart the image.
  task automatic apply_cfg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_HALF_SIZE: half_q = data[2:0];
      REG_ROW_SIZE: rowsz_q = data[11:0];
      REG_CHANNELS: chan_q = data[2:0];
      REG_ROW_COUNT: rowcnt_q = data[15:0];
      REG_RESULT_SHIFT: begin
        shift_q = data[4:0];
        return;
      end
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  // Store one padded element and compute the convolution if its window is complete.
  task automatic convolve_pixel(logic signed [15:0] px);
    int unsigned  h, ch, rs, rc, side, span, prow, rows, pc, pr, c, slot;
    int           i, j;
    longint       acc, res;
    conv_result_t r;
    h = (half_q > MAX_HALF_SIZE) ? MAX_HALF_SIZE : half_q;
    ch = (chan_q == 0) ? 1 : ((chan_q > MAX_CHANNELS) ? MAX_CHANNELS : chan_q);
    rs = (rowsz_q == 0) ? 1 : rowsz_q;
    rc = (rowcnt_q == 0) ? 1 : rowcnt_q;
    side = 2 * h + 1;
    span = 2 * h * ch;
    prow = rs + span;
    rows = rc + 2 * h;
    pc = col_pos;
    pr = row_pos;
    line_rows[pr % side][pc % MAX_PADDED_ROW] = px;
    if (pr >= 2 * h && pc >= span) begin
      c = pc - span;
      acc = 0;
      for (i = 0; i < side; i++) begin
        slot = (pr - 2 * h + i) % side;
        for (j = 0; j < side; j++) begin
          acc += longint'(line_rows[slot][(c + j * ch) % MAX_PADDED_ROW]) *
                 longint'(kernel_taps[i * side + j]);
        end
      end
      res = acc >>> shift_q;
      r.sat = 1'b0;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        r.sat = 1'b1;
      end
      if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        r.sat = 1'b1;
      end
      r.value = res[31:0];
      r.last = (pc + 1 >= prow) && (pr + 1 >= rows);
      conv_results_q.push_back(r);
    end
    if (pc + 1 >= prow) begin
      col_pos = 0;
      row_pos = (pr + 1 >= rows) ? 0 : pr + 1;
    end else begin
      col_pos = pc + 1;
    end
  endtask

  // Watch all three channels; results are compared before new inputs are predicted.
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      half_q = 3'd1;
      rowsz_q = 12'd64;
      chan_q = 3'd1;
      rowcnt_q = 16'd64;
      shift_q = 5'd14;
      col_pos = 0;
      row_pos = 0;
      for (int t = 0; t < TAPS_MAX; t++) kernel_taps[t] = '0;
      conv_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (conv_results_q.size() == 0) begin
          report_mismatch("result with none expected", $signed(out_result_value), 0);
        end else begin
          want = conv_results_q.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("result_value", $signed(out_result_value), $signed(want.value));
          if (out_saturated !== want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
          if (out_last_of_image !== want.last)
            report_mismatch("last_of_image", out_last_of_image, want.last);
        end
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_COEF) begin
          if (in_coef_index < TAPS_MAX) kernel_taps[in_coef_index] = in_coef_value;
        end else begin
          convolve_pixel(in_pixel_value);
        end
      end
    end
    outstanding <= conv_results_q.size();
  end

  initial mismatch_cnt = 0;

endmodule

FILE: test/tb_padded_2d_convolution.sv
`timescale 1ns / 1ps

module tb_padded_2d_convolution;
  import pc2d_pkg::*;

  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 100;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         TAPS_MAX       = 81;
  localparam int         RANDOM_PIXELS  = 600;
  localparam int         MIN_PHASES     = 4;
  localparam logic [2:0] REG_UNUSED     = 3'd5;
  localparam int         VAL_RANDOM     = 0;
  localparam int         VAL_EXTREME    = 1;
  localparam int         VAL_SMALL      = 2;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [6:0]  in_coef_index;
  logic [15:0] in_coef_value;
  logic [15:0] in_pixel_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_value;
  logic        out_saturated;
  logic        out_last_of_image;
  int          mismatches;
  int          outstanding;
  int          hold_reqs;
  int          holds_done;
  int          idle_cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  padded_2d_convolution u_top (.*);

  pc2d_checker u_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_func, .in_coef_index, .in_coef_value, .in_pixel_value,
    .out_valid, .out_stall, .out_result_value, .out_saturated, .out_last_of_image,
    .errors(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result receiver: random stall after each transaction, plus requested long hold-offs.
  initial begin
    int gap;
    out_stall = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        gap = rx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register value with random bits above the field.
  function automatic logic [15:0] with_noise(int value, int width);
    logic [15:0] mask;
    mask = 16'((32'd1 << width) - 1);
    return (16'($urandom) & ~mask) | (16'(value) & mask);
  endfunction

  // Wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic f, logic [6:0] idx, logic [15:0] cv, logic [15:0] pv);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func <= f;
    in_coef_index <= idx;
    in_coef_value <= cv;
    in_pixel_value <= pv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [15:0] sample16(int mode);
    case (mode)
      VAL_EXTREME: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      VAL_SMALL: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Configure the geometry, load the whole kernel in use, then stream pixels.
  task automatic run_phase(int h_cfg, int rs_cfg, int ch_cfg, int rc_cfg, int sh,
                           int pixels, int mode, bit hold, bit pause);
    int h_eff, side, t, k;
    wait_idle();
    cfg_write(REG_HALF_SIZE, with_noise(h_cfg, 3));
    cfg_write(REG_ROW_SIZE, with_noise(rs_cfg, 12));
    cfg_write(REG_CHANNELS, with_noise(ch_cfg, 3));
    cfg_write(REG_ROW_COUNT, with_noise(rc_cfg, 16));
    cfg_write(REG_RESULT_SHIFT, with_noise(sh, 5));
    h_eff = (h_cfg > 4) ? 4 : h_cfg;
    side = 2 * h_eff + 1;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    for (t = 0; t < side * side; t++)
      send_item(FUNC_COEF, 7'(t), sample16(mode), 16'($urandom));
    if (hold) hold_reqs++;
    for (k = 0; k < pixels; k++) begin
      if (pause && k == pixels / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      // Occasional coefficient transactions inside the stream, some to ignored indexes.
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) != 0)
          send_item(FUNC_COEF, 7'($urandom_range(TAPS_MAX, 127)), 16'($urandom),
                    16'($urandom));
        else
          send_item(FUNC_COEF, 7'($urandom_range(0, side * side - 1)), sample16(mode),
                    16'($urandom));
      end
      send_item(FUNC_PIXEL, 7'($urandom), 16'($urandom), sample16(mode));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int sent, phase_no, h, ch, rs, rc, prow, rows, image, n;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = FUNC_PIXEL;
    in_coef_index = '0;
    in_coef_value = '0;
    in_pixel_value = '0;
    hold_reqs = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(REG_UNUSED, 16'($urandom));

    // Directed: smallest image, largest clamped geometry, zero geometry, wide channels.
    run_phase(0, 1, 1, 1, 0, 3, VAL_EXTREME, 1'b0, 1'b0);
    run_phase(7, 0, 0, 0, 31, 20, VAL_EXTREME, 1'b0, 1'b0);
    run_phase(4, 1, 1, 1, 0, 81, VAL_EXTREME, 1'b0, 1'b0);
    run_phase(1, 2, 7, 1, 14, 30, VAL_RANDOM, 1'b0, 1'b0);

    // Random geometries with whole images, image wraps and partial images.
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_PIXELS || phase_no < MIN_PHASES) begin
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      rs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      rc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if (phase_no == 1 || phase_no == 3) begin
        h = 1;
        ch = 1;
        rs = 8;
        rc = 3;
      end
      prow = ((rs == 0) ? 1 : rs) + 2 * ((h > 4) ? 4 : h) * ((ch == 0) ? 1 : ((ch > 4) ? 4 : ch));
      rows = ((rc == 0) ? 1 : rc) + 2 * ((h > 4) ? 4 : h);
      image = prow * rows;
      case ($urandom_range(0, 3))
        0: n = $urandom_range(1, image);
        1: n = image * 2;
        default: n = image;
      endcase
      // The long hold-off needs enough results to fill the block.
      if (phase_no == 1) n = image * 2;
      if (n > 400) n = 400;
      run_phase(h, rs, ch, rc, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31), n,
                $urandom_range(VAL_RANDOM, VAL_SMALL), phase_no == 1, phase_no == 3);
      sent += n;
      phase_no++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
